// File: rtl/core/bfifo_pkg.sv
package bfifo_pkg;

  localparam int unsigned DepthDefault = 256;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned ReqW    = 4;
  localparam int unsigned StepW   = 9;
  localparam int unsigned InDataW = 32;
  localparam int unsigned OutDataW = 32;

  typedef enum logic [ReqW-1:0] {
    REQ_WRITE     = 4'd0,
    REQ_READ      = 4'd1,
    REQ_TW_BEGIN  = 4'd2,
    REQ_TW_END    = 4'd3,
    REQ_TR_BEGIN  = 4'd4,
    REQ_TR_END    = 4'd5,
    REQ_ADV_WRITE = 4'd6,
    REQ_ADV_READ  = 4'd7,
    REQ_SET_READ  = 4'd8,
    REQ_CLEAR     = 4'd9
  } req_e;

endpackage

// File: rtl/core/bfifo_ram.sv
module bfifo_ram #(
  parameter int unsigned DEPTH = bfifo_pkg::DepthDefault,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [AW-1:0]                waddr_i,
  input  logic [bfifo_pkg::ByteW-1:0]  wdata_i,
  input  logic                         re_i,
  input  logic [AW-1:0]                raddr_i,
  output logic [bfifo_pkg::ByteW-1:0]  rdata_o
);

  logic [bfifo_pkg::ByteW-1:0] mem [DEPTH];
  logic [bfifo_pkg::ByteW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/byte_ring_fifo_with_tentative_modes.sv
// Byte ring FIFO with tentative (shadow pointer) write and read modes.
// Requests enter on the s_axis channel, one word per request; every request
// produces exactly one status word on the m_axis channel, in order.
// Request kinds: write, read, begin/end tentative write, begin/end tentative
// read (end commits the shadow pointer when commit is set), advance write or
// read pointer by step_count modulo DEPTH, set read index, clear.
// Latency: the result word is valid in the cycle after the request is taken.
// Throughput: one request per cycle. Each request updates pointers on
// registers and makes at most one access to the DEPTH x 8 storage array
// (one write port, one registered read port); the read byte comes out of
// that port's read register, which doubles as the result register.
// Reset: pointers and mode bits clear, the result register empties; the
// storage contents are undefined until written.
// Stall: while a result waits and m_axis_tready_i is low, s_axis_tready_o
// drops and the result word holds; a result taken in the same cycle frees
// the slot, so requests keep flowing back to back.
module byte_ring_fifo_with_tentative_modes #(
  parameter int unsigned DEPTH = bfifo_pkg::DepthDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // write_data[7:0], commit[8], step_count[17:9], read_index[25:18], zero
  input  logic [bfifo_pkg::InDataW-1:0]       s_axis_tdata_i,
  // req_type[3:0]
  input  logic [bfifo_pkg::ReqW-1:0]          s_axis_tuser_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // read_data[7:0], read_ok[8], fill_count[16:9], is_empty[17], is_full[18],
  // tentative_count[26:19], zero
  output logic [bfifo_pkg::OutDataW-1:0]      m_axis_tdata_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned SW = bfifo_pkg::StepW;
  localparam int unsigned BW = bfifo_pkg::ByteW;

  // reduce a 9-bit amount modulo DEPTH by restoring subtraction
  function automatic logic [SW-1:0] mod_depth(input logic [SW-1:0] n);
    logic [SW-1:0] r;
    r = n;
    for (int k = 7; k >= 0; k--) begin
      if ((DEPTH << k) < (1 << SW)) begin
        if (32'(r) >= (DEPTH << k)) begin
          r = r - SW'(DEPTH << k);
        end
      end
    end
    return r;
  endfunction

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] p,
                                             input logic [SW-1:0] n);
    logic [AW:0] s;
    s = {1'b0, p} + (AW+1)'(mod_depth(n));
    if (s >= (AW+1)'(DEPTH)) begin
      s = s - (AW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] ring_diff(input logic [AW-1:0] w,
                                              input logic [AW-1:0] r);
    logic [AW:0] d;
    if (w >= r) begin
      d = {1'b0, w} - {1'b0, r};
    end else begin
      d = {1'b0, w} + (AW+1)'(DEPTH) - {1'b0, r};
    end
    return d[AW-1:0];
  endfunction

  function automatic logic [BW-1:0] low_byte(input logic [AW-1:0] v);
    logic [AW+BW-1:0] ext;
    ext = {{BW{1'b0}}, v};
    return ext[BW-1:0];
  endfunction

  logic [AW-1:0] wp_q, wp_d, rp_q, rp_d, swp_q, swp_d, srp_q, srp_d;
  logic          tw_on_q, tw_on_d, tr_on_q, tr_on_d;

  logic             accept;
  bfifo_pkg::req_e  req;
  logic [BW-1:0]    wdata;
  logic             commit;
  logic [SW-1:0]    steps;
  logic [BW-1:0]    ridx;

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [BW-1:0] mem_rdata;

  logic          rok_d;
  logic [AW-1:0] fill_d, tfill_d;

  logic          out_valid_q;
  logic          rok_q, empty_q, full_q;
  logic [BW-1:0] fill_q, tfill_q;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  assign req    = bfifo_pkg::req_e'(s_axis_tuser_i);
  assign wdata  = s_axis_tdata_i[7:0];
  assign commit = s_axis_tdata_i[8];
  assign steps  = s_axis_tdata_i[17:9];
  assign ridx   = s_axis_tdata_i[25:18];

  always_comb begin
    wp_d      = wp_q;
    rp_d      = rp_q;
    swp_d     = swp_q;
    srp_d     = srp_q;
    tw_on_d   = tw_on_q;
    tr_on_d   = tr_on_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = tw_on_q ? swp_q : wp_q;
    mem_raddr = tr_on_q ? srp_q : rp_q;
    rok_d     = 1'b0;
    unique case (req)
      bfifo_pkg::REQ_WRITE: begin
        mem_we = accept;
        if (tw_on_q) begin
          swp_d = wrap_add(swp_q, SW'(1));
        end else begin
          wp_d = wrap_add(wp_q, SW'(1));
        end
      end
      bfifo_pkg::REQ_READ: begin
        // empty test always on the committed pointers
        if (wp_q != rp_q) begin
          mem_re = accept;
          rok_d  = 1'b1;
          if (tr_on_q) begin
            srp_d = wrap_add(srp_q, SW'(1));
          end else begin
            rp_d = wrap_add(rp_q, SW'(1));
          end
        end
      end
      bfifo_pkg::REQ_TW_BEGIN: begin
        if (!tw_on_q) begin
          swp_d   = wp_q;
          tw_on_d = 1'b1;
        end
      end
      bfifo_pkg::REQ_TW_END: begin
        tw_on_d = 1'b0;
        if (commit) begin
          wp_d = swp_q;
        end
      end
      bfifo_pkg::REQ_TR_BEGIN: begin
        srp_d   = rp_q;
        tr_on_d = 1'b1;
      end
      bfifo_pkg::REQ_TR_END: begin
        tr_on_d = 1'b0;
        if (commit) begin
          rp_d = srp_q;
        end
      end
      bfifo_pkg::REQ_ADV_WRITE: wp_d = wrap_add(wp_q, steps);
      bfifo_pkg::REQ_ADV_READ:  rp_d = wrap_add(rp_q, steps);
      bfifo_pkg::REQ_SET_READ:  rp_d = wrap_add('0, {1'b0, ridx});
      bfifo_pkg::REQ_CLEAR: begin
        wp_d    = '0;
        rp_d    = '0;
        tw_on_d = 1'b0;
        tr_on_d = 1'b0;
      end
      default: ;
    endcase
    fill_d  = ring_diff(wp_d, rp_d);
    tfill_d = tw_on_d ? ring_diff(swp_d, rp_d) : fill_d;
  end

  bfifo_ram #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q        <= '0;
      rp_q        <= '0;
      swp_q       <= '0;
      srp_q       <= '0;
      tw_on_q     <= 1'b0;
      tr_on_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        wp_q    <= wp_d;
        rp_q    <= rp_d;
        swp_q   <= swp_d;
        srp_q   <= srp_d;
        tw_on_q <= tw_on_d;
        tr_on_q <= tr_on_d;
      end
      if (s_axis_tready_o) begin
        out_valid_q <= s_axis_tvalid_i;
      end
    end
  end

  // result word; holds while the receiver stalls
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rok_q   <= rok_d;
      fill_q  <= low_byte(fill_d);
      empty_q <= (wp_d == rp_d);
      full_q  <= ({1'b0, fill_d} >= (AW+1)'(DEPTH - 1));
      tfill_q <= low_byte(tfill_d);
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'b0, tfill_q, full_q, empty_q, fill_q, rok_q,
                            rok_q ? mem_rdata : {BW{1'b0}}};

endmodule
